### hw/rtl/tia_pkg.sv
package tia_pkg;

  localparam int DataWidth = 64;
  localparam int ShW = $clog2(DataWidth);
  // Number of quotient bits, or multiplier bits, that one cell handles.
  localparam int BitsPerCell = 4;
  localparam int NumCells = DataWidth / BitsPerCell;

  localparam logic [3:0] KindAdd  = 4'd0;
  localparam logic [3:0] KindSub  = 4'd1;
  localparam logic [3:0] KindMul  = 4'd2;
  localparam logic [3:0] KindDiv  = 4'd3;
  localparam logic [3:0] KindRem  = 4'd4;
  localparam logic [3:0] KindAnd  = 4'd5;
  localparam logic [3:0] KindOr   = 4'd6;
  localparam logic [3:0] KindXor  = 4'd7;
  localparam logic [3:0] KindShl  = 4'd8;
  localparam logic [3:0] KindShr  = 4'd9;
  localparam logic [3:0] KindEq   = 4'd10;
  localparam logic [3:0] KindNe   = 4'd11;
  localparam logic [3:0] KindGt   = 4'd12;
  localparam logic [3:0] KindGe   = 4'd13;
  localparam logic [3:0] KindCast = 4'd14;

  localparam logic [3:0] TargetPtr = 4'd8;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatDivZero = 2'd1;
  localparam logic [1:0] StatBadCast = 2'd2;

  // One word as it moves down the chain.
  typedef struct packed {
    logic                 vld;
    logic [1:0]           wsel;   // log2 of width in bytes
    logic                 sgn;
    logic                 is_div; // result comes from the divider
    logic                 is_mul; // result is the product built in the chain
    logic                 want_rem;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] rem;    // partial remainder, or product sum
    logic [DataWidth-1:0] quo;    // dividend shifting into quotient, or multiplicand
    logic [DataWidth-1:0] dvs;    // divisor magnitude, or multiplier bits left
    logic [DataWidth-1:0] res;    // finished result for other words
    logic [1:0]           status;
  } tia_word_t;

  function automatic logic [DataWidth-1:0] fit(input logic [DataWidth-1:0] v,
                                               input logic [1:0] wsel,
                                               input logic sgn);
    logic [DataWidth-1:0] r;
    r = v;
    unique case (wsel)
      2'd0: r = sgn ? {{(DataWidth-8){v[7]}}, v[7:0]} : {{(DataWidth-8){1'b0}}, v[7:0]};
      2'd1: r = sgn ? {{(DataWidth-16){v[15]}}, v[15:0]} : {{(DataWidth-16){1'b0}}, v[15:0]};
      2'd2: r = sgn ? {{(DataWidth-32){v[31]}}, v[31:0]} : {{(DataWidth-32){1'b0}}, v[31:0]};
      2'd3: r = v;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/typed_integer_alu.sv
// Typed integer ALU: each word carries an operation, an operand type and two
// operands, and yields one result word with a status code. One word is taken
// every cycle unless back-pressure stalls the chain. Every word, whatever its
// operation, travels through one entry register, a chain of NumCells cells
// and an output register. Each cell resolves four quotient bits of a
// division, or adds four partial products of a multiplication, and results
// leave in order. The whole chain advances whenever the output register is
// empty or being taken, so back-pressure stalls it as one unit.
module typed_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [2:0]  in_operand_type,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic [3:0]  in_target_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic [1:0]  out_status
);
  import tia_pkg::*;

  logic adv;
  tia_word_t chain [NumCells+1];
  tia_word_t last;
  logic [DataWidth-1:0] fin_nxt, sel;
  logic out_valid_r;
  logic [DataWidth-1:0] out_value_r;
  logic [1:0] out_status_r;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;

  tia_front u_front (
    .clk, .rst_n, .adv,
    .in_fire(in_valid && in_ready),
    .kind(in_kind), .operand_type(in_operand_type),
    .operand_a(in_operand_a), .operand_b(in_operand_b),
    .target_type(in_target_type),
    .word_r(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    tia_cell u_cell (.clk, .rst_n, .adv, .word_i(chain[g]), .word_r(chain[g+1]));
  end

  assign last = chain[NumCells];

  // Sign correction of the quotient or remainder; MIN / -1 wraps to MIN here.
  // A product only needs to be cut to its type width.
  always_comb begin
    if (last.want_rem) sel = last.neg_r ? -last.rem : last.rem;
    else sel = last.neg_q ? -last.quo : last.quo;
    if (last.is_div) fin_nxt = fit(sel, last.wsel, last.sgn);
    else if (last.is_mul) fin_nxt = fit(last.rem, last.wsel, last.sgn);
    else fin_nxt = last.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
    end
    if (adv) begin
      out_value_r <= fin_nxt;
      out_status_r <= last.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status = out_status_r;
endmodule

### hw/rtl/tia_front.sv
module tia_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_fire,
  input  logic [3:0]                   kind,
  input  logic [2:0]                   operand_type,
  input  logic [tia_pkg::DataWidth-1:0] operand_a,
  input  logic [tia_pkg::DataWidth-1:0] operand_b,
  input  logic [3:0]                   target_type,
  output tia_pkg::tia_word_t           word_r
);
  import tia_pkg::*;

  logic [1:0] wsel;
  logic sgn;
  logic [DataWidth-1:0] a, b, amt, r, ma, mb, shr_v;
  logic [1:0] st;
  logic big, fill, gt, mul;
  tia_word_t word_nxt;

  assign wsel = operand_type[1:0];
  assign sgn  = ~operand_type[2];
  assign a = fit(operand_a, wsel, sgn);
  assign b = fit(operand_b, wsel, sgn);
  assign amt = fit(operand_b, wsel, 1'b0);
  assign big = amt >= (DataWidth'(8) << wsel);
  assign fill = sgn & a[DataWidth-1];
  assign ma = a[DataWidth-1] & sgn ? -a : a;
  assign mb = b[DataWidth-1] & sgn ? -b : b;
  assign gt = sgn ? ($signed(a) > $signed(b)) : (a > b);
  assign shr_v = DataWidth'($signed({fill, a}) >>> amt[ShW-1:0]);
  assign mul = kind == KindMul;

  always_comb begin
    r = '0;
    st = StatOk;
    unique case (kind)
      KindAdd: r = fit(a + b, wsel, sgn);
      KindSub: r = fit(a - b, wsel, sgn);
      // The product is accumulated in the cell chain.
      KindMul: r = '0;
      KindDiv, KindRem: st = (b == '0) ? StatDivZero : StatOk;
      KindAnd: r = a & b;
      KindOr:  r = a | b;
      KindXor: r = a ^ b;
      KindShl: r = big ? '0 : fit(a << amt[ShW-1:0], wsel, sgn);
      KindShr: r = big ? {DataWidth{fill}} : fit(shr_v, wsel, sgn);
      KindEq:  r = DataWidth'(a == b);
      KindNe:  r = DataWidth'(a != b);
      KindGt:  r = DataWidth'(gt);
      KindGe:  r = DataWidth'(gt | (a == b));
      KindCast: begin
        if (!target_type[3]) r = fit(a, target_type[1:0], ~target_type[2]);
        else if (target_type == TargetPtr) r = fit(a, 2'd2, 1'b0);
        else st = StatBadCast;
      end
      default: r = '0;
    endcase
  end

  always_comb begin
    word_nxt.vld = in_fire;
    word_nxt.wsel = wsel;
    word_nxt.sgn = sgn;
    word_nxt.is_div = (kind == KindDiv || kind == KindRem) && b != '0;
    word_nxt.is_mul = mul;
    word_nxt.want_rem = kind == KindRem;
    word_nxt.neg_q = sgn & (a[DataWidth-1] ^ b[DataWidth-1]);
    word_nxt.neg_r = sgn & a[DataWidth-1];
    word_nxt.rem = '0;
    word_nxt.quo = mul ? a : ma;
    word_nxt.dvs = mul ? b : mb;
    word_nxt.res = r;
    word_nxt.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (adv) begin
      word_r.vld <= word_nxt.vld;
    end
    if (adv) begin
      word_r.wsel <= word_nxt.wsel;
      word_r.sgn <= word_nxt.sgn;
      word_r.is_div <= word_nxt.is_div;
      word_r.is_mul <= word_nxt.is_mul;
      word_r.want_rem <= word_nxt.want_rem;
      word_r.neg_q <= word_nxt.neg_q;
      word_r.neg_r <= word_nxt.neg_r;
      word_r.rem <= word_nxt.rem;
      word_r.quo <= word_nxt.quo;
      word_r.dvs <= word_nxt.dvs;
      word_r.res <= word_nxt.res;
      word_r.status <= word_nxt.status;
    end
  end
endmodule

### hw/rtl/tia_cell.sv
module tia_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  tia_pkg::tia_word_t word_i,
  output tia_pkg::tia_word_t word_r
);
  import tia_pkg::*;

  tia_word_t word_nxt;
  logic [DataWidth:0] trial;
  logic [DataWidth-1:0] rm, qu, dv;

  // Restoring division, a few quotient bits per cell. Multiply words use
  // the same registers for shift-and-add, one multiplier bit per step.
  always_comb begin
    word_nxt = word_i;
    rm = word_i.rem;
    qu = word_i.quo;
    dv = word_i.dvs;
    trial = '0;
    for (int i = 0; i < BitsPerCell; i++) begin
      if (word_i.is_mul) begin
        if (dv[0]) rm = rm + qu;
        qu = {qu[DataWidth-2:0], 1'b0};
        dv = {1'b0, dv[DataWidth-1:1]};
      end else begin
        trial = {rm, qu[DataWidth-1]} - {1'b0, dv};
        if (!trial[DataWidth]) begin
          rm = trial[DataWidth-1:0];
          qu = {qu[DataWidth-2:0], 1'b1};
        end else begin
          rm = {rm[DataWidth-2:0], qu[DataWidth-1]};
          qu = {qu[DataWidth-2:0], 1'b0};
        end
      end
    end
    word_nxt.rem = rm;
    word_nxt.quo = qu;
    word_nxt.dvs = dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (adv) begin
      word_r.vld <= word_nxt.vld;
    end
    if (adv) begin
      word_r.wsel <= word_nxt.wsel;
      word_r.sgn <= word_nxt.sgn;
      word_r.is_div <= word_nxt.is_div;
      word_r.is_mul <= word_nxt.is_mul;
      word_r.want_rem <= word_nxt.want_rem;
      word_r.neg_q <= word_nxt.neg_q;
      word_r.neg_r <= word_nxt.neg_r;
      word_r.rem <= word_nxt.rem;
      word_r.quo <= word_nxt.quo;
      word_r.dvs <= word_nxt.dvs;
      word_r.res <= word_nxt.res;
      word_r.status <= word_nxt.status;
    end
  end
endmodule
